[hdl/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, suspended while reset is asserted
`define B64_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is checked during reset as well
`define B64_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/b64lw_pkg.sv]
// Shared types, constants and the Base64 alphabet for the line-wrapped encoder.
// No dependencies.
package b64lw_pkg;

  // Group queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int LimitW    = 10;
  localparam int CharIdxW  = 3;

  // Character codes
  localparam logic [7:0] CharPad    = 8'h3d;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] AsciiUpper = 8'h41;
  localparam logic [7:0] AsciiLower = 8'h61;
  localparam logic [7:0] AsciiDigit = 8'h30;

  // How a queued group ends
  typedef enum logic [1:0] {
    KindFull = 2'd0,
    KindPad1 = 2'd1,
    KindPad2 = 2'd2
  } group_kind_e;

  // One group of up to three bytes, ready for output
  typedef struct packed {
    logic [23:0] data;
    group_kind_e kind;
    logic        brk;
    logic        last;
  } group_t;

  // Map a six-bit value onto the standard alphabet
  function automatic logic [7:0] enc_six(input logic [5:0] six);
    logic [7:0] v;
    v = {2'b00, six};
    priority if (six < 6'd26) begin
      return AsciiUpper + v;
    end else if (six < 6'd52) begin
      return AsciiLower + v - 8'd26;
    end else if (six < 6'd62) begin
      return AsciiDigit + v - 8'd52;
    end else if (six == 6'd62) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

endpackage

[hdl/b64lw_fifo.sv]
// Short register queue of byte groups between front and back.
// Depends on b64lw_pkg.
module b64lw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64lw_pkg::group_t push_data_i,
  input  logic              pop_i,
  output b64lw_pkg::group_t head_o,
  output logic              not_empty_o,
  output logic              full_o
);

  b64lw_pkg::group_t                    mem_q [b64lw_pkg::QDepth];
  logic [b64lw_pkg::QPtrW-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [b64lw_pkg::QCntW-1:0]          cnt_q, cnt_d;

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  assign full_o      = (cnt_q == b64lw_pkg::QCntW'(b64lw_pkg::QDepth));

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == b64lw_pkg::QPtrW'(b64lw_pkg::QDepth - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == b64lw_pkg::QPtrW'(b64lw_pkg::QDepth - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed group
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/b64lw_front.sv]
// Front end: accepts bytes, gathers groups of three and decides line breaks.
// Depends on b64lw_pkg.
module b64lw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [b64lw_pkg::LimitW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         message_last_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output b64lw_pkg::group_t            push_data_o
);

  logic [b64lw_pkg::LimitW-1:0] line_limit_q, line_count_q, line_count_d;
  logic [15:0]                  held_q, held_d;
  logic [1:0]                   pos_q, pos_d, pos_eff;
  logic                         accept, finish;
  logic [b64lw_pkg::LimitW:0]   cnt;
  logic                         brk_due;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign pos_eff    = (pos_q == 2'd3) ? 2'd0 : pos_q;
  assign finish     = message_last_i || (pos_eff == 2'd2);
  assign push_o     = accept && finish;

  // Break test without wrap: count + 4 + 4 > limit
  assign cnt     = {1'b0, line_count_q} + (b64lw_pkg::LimitW + 1)'(4);
  assign brk_due = ({1'b0, cnt} + (b64lw_pkg::LimitW + 2)'(4)) > {2'b00, line_limit_q};

  // Build the group for the queue
  always_comb begin
    push_data_o.last = message_last_i;
    push_data_o.brk  = 1'b0;
    unique case (pos_eff)
      2'd0: begin
        push_data_o.data = {data_byte_i, 16'h0000};
        push_data_o.kind = b64lw_pkg::KindPad2;
      end
      2'd1: begin
        push_data_o.data = {held_q[15:8], data_byte_i, 8'h00};
        push_data_o.kind = b64lw_pkg::KindPad1;
      end
      default: begin
        push_data_o.data = {held_q, data_byte_i};
        push_data_o.kind = b64lw_pkg::KindFull;
        push_data_o.brk  = brk_due;
      end
    endcase
  end

  // Hold pending bytes and track the line count
  always_comb begin
    held_d       = held_q;
    pos_d        = pos_q;
    line_count_d = line_count_q;
    if (accept) begin
      if (finish) begin
        held_d = '0;
        pos_d  = '0;
        if (message_last_i || push_data_o.brk) begin
          line_count_d = '0;
        end else begin
          line_count_d = cnt[b64lw_pkg::LimitW-1:0];
        end
      end else begin
        held_d = (pos_eff == 2'd0) ? {data_byte_i, 8'h00} : {held_q[15:8], data_byte_i};
        pos_d  = pos_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= b64lw_pkg::LimitW'(76);
      line_count_q <= '0;
      held_q       <= '0;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        line_limit_q <= cfg_wdata_i;
      end
      line_count_q <= line_count_d;
      held_q       <= held_d;
      pos_q        <= pos_d;
    end
  end

endmodule

[hdl/b64lw_back.sv]
// Back end: turns queued groups into characters in an output register, one per
// cycle unless the output stalls. Depends on b64lw_pkg.
module b64lw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64lw_pkg::group_t job_i,
  input  logic              job_valid_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              run_last_o,
  output logic              message_end_o
);

  logic [b64lw_pkg::CharIdxW-1:0] idx_q, idx_d, last_idx;
  logic                           out_valid_q, out_valid_d;
  logic [7:0]                     char_q, char_d;
  logic                           run_last_q, message_end_q;
  logic                           load, at_end;

  assign last_idx = job_i.brk ? b64lw_pkg::CharIdxW'(5) : b64lw_pkg::CharIdxW'(3);
  assign at_end   = (idx_q == last_idx);
  assign load     = job_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && at_end;

  // Select the character at the current position of the group
  always_comb begin
    unique case (idx_q)
      3'd0: char_d = b64lw_pkg::enc_six(job_i.data[23:18]);
      3'd1: char_d = b64lw_pkg::enc_six(job_i.data[17:12]);
      3'd2: char_d = (job_i.kind == b64lw_pkg::KindPad2) ? b64lw_pkg::CharPad
                                                         : b64lw_pkg::enc_six(job_i.data[11:6]);
      3'd3: char_d = (job_i.kind != b64lw_pkg::KindFull) ? b64lw_pkg::CharPad
                                                         : b64lw_pkg::enc_six(job_i.data[5:0]);
      3'd4: char_d = b64lw_pkg::CharCr;
      default: char_d = b64lw_pkg::CharLf;
    endcase
  end

  // Advance position and output valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = at_end ? '0 : idx_q + 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q        <= char_d;
      run_last_q    <= at_end;
      message_end_q <= at_end && job_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = char_q;
  assign run_last_o    = run_last_q;
  assign message_end_o = message_end_q;

endmodule

[hdl/base64_line_wrapped_encoder.sv]
// Line-wrapped Base64 encoder, top level.
// Depends on b64lw_pkg, b64lw_front, b64lw_fifo and b64lw_back.
//
// Input channel: one raw byte per item (data_byte_i, message_last_i), taken at
// an edge where in_valid_i is high and in_stall_o low. Output channel: one
// character per item (out_char_o, run_last_o, message_end_o), delivered where
// out_valid_o is high and out_stall_i low. cfg_we_i writes the line limit
// (reset 76); write it only while the block is idle.
// Every third byte, or the last byte of a message, forms a group that the front
// end queues; the back end emits four characters, plus CR LF when the line is
// full, one per cycle while the receiver does not stall. With the back end free,
// a group passes the group queue and then the output register before its first
// character is shown. The single character output port limits the rate: a
// full group gives four characters (six with CR LF); bytes are taken every
// cycle while the two-entry group queue has room. When the receiver stalls,
// the output register holds its character and the queue fills, after which
// in_stall_o rises. Reset clears pending bytes, line count, queue and output
// valid, and restores the line limit.
module base64_line_wrapped_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [b64lw_pkg::LimitW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         message_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_char_o,
  output logic                         run_last_o,
  output logic                         message_end_o
);

  b64lw_pkg::group_t push_data, head;
  logic              push, pop, q_full, q_not_empty;

  // Gather bytes into groups
  b64lw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .message_last_i (message_last_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // Decouple front and back
  b64lw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  // Emit characters
  b64lw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head),
    .job_valid_i   (q_not_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

[hdl/b64lw_checker.sv]
// Port-level checks for the line-wrapped Base64 encoder, bound to the top level.
// Depends on b64lw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b64lw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       run_last_o,
  input logic       message_end_o
);

  // Hold a stalled output item
  `B64_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output item dropped under stall")

  // No output during reset
  `B64_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

  // End of message closes the run of its byte
  `B64_ASSERT(a_end_run, clk_i, rst_ni, out_valid_o |-> (!message_end_o || run_last_o), "message end without run end")

  // A taken CR is followed at once by the LF that ends the run
  `B64_ASSERT(a_cr_lf, clk_i, rst_ni, out_valid_o && !out_stall_i && (out_char_o == b64lw_pkg::CharCr) |=> out_valid_o && (out_char_o == b64lw_pkg::CharLf) && run_last_o, "CR not followed by LF")

  // A first padding character is followed at once by the second, closing the run
  `B64_ASSERT(a_pad_pair, clk_i, rst_ni, out_valid_o && !out_stall_i && (out_char_o == b64lw_pkg::CharPad) && !run_last_o |=> out_valid_o && (out_char_o == b64lw_pkg::CharPad) && run_last_o, "padding pair broken")

endmodule

bind base64_line_wrapped_encoder b64lw_checker u_b64lw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_char_o     (out_char_o),
  .run_last_o     (run_last_o),
  .message_end_o  (message_end_o)
);
